// File: rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// Touch tap and swipe detector package
// Shared constants, register codes and the configuration bundle.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int COORD_BITS_DEFAULT = 12;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 24;

  localparam int CONFIRM_BITS  = 10;
  localparam int TOL_BITS      = 24;
  localparam int SWIPE_BITS    = 12;
  localparam int POLL_CFG_BITS = 10;
  localparam int POLL_CNT_BITS = 11;

  localparam logic [CONFIRM_BITS-1:0]  CONFIRM_TICKS_RST = 10'd60;
  localparam logic [TOL_BITS-1:0]      TOLERANCE_SQ_RST  = 24'd900;
  localparam logic [SWIPE_BITS-1:0]    SWIPE_MIN_DX_RST  = 12'd150;
  localparam logic [SWIPE_BITS-1:0]    SWIPE_MIN_DY_RST  = 12'd150;
  localparam logic [POLL_CFG_BITS-1:0] POLL_INTERVAL_RST = 10'd30;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_CONFIRM_TICKS = 3'd0,
    REG_TOLERANCE_SQ  = 3'd1,
    REG_SWIPE_MIN_DX  = 3'd2,
    REG_SWIPE_MIN_DY  = 3'd3,
    REG_POLL_INTERVAL = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SWIPE_NONE  = 2'd0,
    SWIPE_HORIZ = 2'd1,
    SWIPE_VERT  = 2'd2
  } swipe_kind_t;

  typedef struct packed {
    logic [CONFIRM_BITS-1:0]  confirm_ticks;
    logic [TOL_BITS-1:0]      tolerance_sq;
    logic [SWIPE_BITS-1:0]    swipe_min_dx;
    logic [SWIPE_BITS-1:0]    swipe_min_dy;
    logic [POLL_CFG_BITS-1:0] poll_interval;
  } cfg_t;

endpackage

// File: rtl/tts_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the five settings and decodes register writes.
// ----------------------------------------------------------------------------
module tts_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tts_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [tts_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output tts_pkg::cfg_t                    cfg
);
  import tts_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_CONFIRM_TICKS: cfg_nxt.confirm_ticks = cfg_data[CONFIRM_BITS-1:0];
        REG_TOLERANCE_SQ:  cfg_nxt.tolerance_sq  = cfg_data[TOL_BITS-1:0];
        REG_SWIPE_MIN_DX:  cfg_nxt.swipe_min_dx  = cfg_data[SWIPE_BITS-1:0];
        REG_SWIPE_MIN_DY:  cfg_nxt.swipe_min_dy  = cfg_data[SWIPE_BITS-1:0];
        REG_POLL_INTERVAL: cfg_nxt.poll_interval = cfg_data[POLL_CFG_BITS-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.confirm_ticks <= CONFIRM_TICKS_RST;
      cfg_r.tolerance_sq  <= TOLERANCE_SQ_RST;
      cfg_r.swipe_min_dx  <= SWIPE_MIN_DX_RST;
      cfg_r.swipe_min_dy  <= SWIPE_MIN_DY_RST;
      cfg_r.poll_interval <= POLL_INTERVAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/tts_in_stage.sv
// ----------------------------------------------------------------------------
// Input register stage
// Captures one tick request and hands it on when the result stage has room.
// ----------------------------------------------------------------------------
module tts_in_stage #(
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,
  input  logic              down_ready,
  output logic              advance,
  output logic [DATA_W-1:0] item_data
);

  logic              valid_r;
  logic              valid_nxt;
  logic [DATA_W-1:0] data_r;

  assign advance   = valid_r && down_ready;
  assign in_tready = !valid_r || down_ready;
  assign item_data = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
    end
  end

endmodule

// File: rtl/tts_gesture.sv
// ----------------------------------------------------------------------------
// Gesture logic
// Touch state, counters, tap confirmation and swipe classification.
// ----------------------------------------------------------------------------
module tts_gesture #(
  parameter int COORD_BITS = tts_pkg::COORD_BITS_DEFAULT,
  parameter int IN_W       = 32,
  parameter int OUT_W      = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tts_pkg::cfg_t    cfg,
  input  logic             advance,
  input  logic [IN_W-1:0]  item_data,
  output logic [OUT_W-1:0] res_data
);
  import tts_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int CW    = (C > SWIPE_BITS) ? C : SWIPE_BITS;
  localparam int SQ_W  = (2 * C + 1 > TOL_BITS) ? 2 * C + 1 : TOL_BITS;
  localparam int RES_W = 2 * C + 6;
  localparam logic [CONFIRM_BITS-1:0]  CONFIRM_MAX = '1;
  localparam logic [POLL_CNT_BITS-1:0] POLL_MAX    = '1;

  logic                     active_r, active_nxt;
  logic                     confirm_done_r, confirm_done_nxt;
  logic [C-1:0]             start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic [C-1:0]             last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic [CONFIRM_BITS-1:0]  confirm_count_r, confirm_count_nxt;
  logic [POLL_CNT_BITS-1:0] poll_count_r, poll_count_nxt;

  logic                     irq, down;
  logic [C-1:0]             x, y;
  logic                     press, check, poll, tap;
  logic [C-1:0]             tdx, tdy, adx, ady;
  logic [2*C-1:0]           sqx, sqy;
  logic [SQ_W-1:0]          dist_sq;
  swipe_kind_t              kind;
  logic                     fwd, released;

  assign irq  = item_data[0];
  assign down = item_data[1];
  assign x    = item_data[2 +: C];
  assign y    = item_data[2 + C +: C];

  always_comb begin
    active_nxt        = active_r;
    confirm_done_nxt  = confirm_done_r;
    start_x_nxt       = start_x_r;
    start_y_nxt       = start_y_r;
    last_x_nxt        = last_x_r;
    last_y_nxt        = last_y_r;
    confirm_count_nxt = (confirm_count_r == CONFIRM_MAX) ? confirm_count_r
                                                         : confirm_count_r + 1'b1;
    poll_count_nxt    = (poll_count_r == POLL_MAX) ? poll_count_r
                                                   : poll_count_r + 1'b1;

    press = irq && !active_r && down;
    if (press) begin
      active_nxt        = 1'b1;
      confirm_done_nxt  = 1'b0;
      start_x_nxt       = x;
      start_y_nxt       = y;
      last_x_nxt        = x;
      last_y_nxt        = y;
      confirm_count_nxt = '0;
    end

    tdx     = (x >= start_x_nxt) ? x - start_x_nxt : start_x_nxt - x;
    tdy     = (y >= start_y_nxt) ? y - start_y_nxt : start_y_nxt - y;
    sqx     = (2*C)'(tdx) * (2*C)'(tdx);
    sqy     = (2*C)'(tdy) * (2*C)'(tdy);
    dist_sq = SQ_W'(sqx) + SQ_W'(sqy);

    check = active_nxt && !confirm_done_nxt && (confirm_count_nxt >= cfg.confirm_ticks);
    tap   = check && down && (dist_sq <= SQ_W'(cfg.tolerance_sq));
    if (check) begin
      confirm_done_nxt = 1'b1;
    end

    adx      = (last_x_nxt >= start_x_nxt) ? last_x_nxt - start_x_nxt
                                           : start_x_nxt - last_x_nxt;
    ady      = (last_y_nxt >= start_y_nxt) ? last_y_nxt - start_y_nxt
                                           : start_y_nxt - last_y_nxt;
    kind     = SWIPE_NONE;
    fwd      = 1'b0;
    released = 1'b0;
    poll     = active_nxt &&
               (poll_count_nxt > POLL_CNT_BITS'(cfg.poll_interval));
    if (poll) begin
      poll_count_nxt = '0;
      if (down) begin
        last_x_nxt = x;
        last_y_nxt = y;
      end else begin
        active_nxt = 1'b0;
        released   = 1'b1;
        if (CW'(adx) >= CW'(cfg.swipe_min_dx) && ady < adx) begin
          kind = SWIPE_HORIZ;
          fwd  = last_x_nxt > start_x_nxt;
        end else if (CW'(ady) >= CW'(cfg.swipe_min_dy) && adx < ady) begin
          kind = SWIPE_VERT;
          fwd  = last_y_nxt > start_y_nxt;
        end
      end
    end
  end

  assign res_data = OUT_W'({active_nxt, released, fwd, kind,
                            tap ? start_y_nxt : {C{1'b0}},
                            tap ? start_x_nxt : {C{1'b0}}, tap});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r        <= 1'b0;
      confirm_done_r  <= 1'b0;
      start_x_r       <= '0;
      start_y_r       <= '0;
      last_x_r        <= '0;
      last_y_r        <= '0;
      confirm_count_r <= '0;
      poll_count_r    <= '0;
    end else if (advance) begin
      active_r        <= active_nxt;
      confirm_done_r  <= confirm_done_nxt;
      start_x_r       <= start_x_nxt;
      start_y_r       <= start_y_nxt;
      last_x_r        <= last_x_nxt;
      last_y_r        <= last_y_nxt;
      confirm_count_r <= confirm_count_nxt;
      poll_count_r    <= poll_count_nxt;
    end
  end

  logic unused_ok;
  assign unused_ok = ^{RES_W'(0), item_data};

  a_release_ends_touch: assert property (@(posedge clk) disable iff (!rst_n)
    advance && released |=> !active_r)
    else $error("touch still active after release");

  a_tap_uses_check: assert property (@(posedge clk) disable iff (!rst_n)
    advance && tap |=> confirm_done_r && active_r)
    else $error("tap reported without a finished confirm check");

  a_swipe_needs_release: assert property (@(posedge clk) disable iff (!rst_n)
    advance && kind != SWIPE_NONE |-> released)
    else $error("swipe reported without release");

  a_press_starts_touch: assert property (@(posedge clk) disable iff (!rst_n)
    advance && press |=> confirm_count_r == '0 || !active_r)
    else $error("press did not restart the confirm counter");

endmodule

// File: rtl/tts_out_stage.sv
// ----------------------------------------------------------------------------
// Result register stage
// Holds one result request until the receiver takes it.
// ----------------------------------------------------------------------------
module tts_out_stage #(
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [DATA_W-1:0] res_data,
  output logic              up_ready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata
);

  logic              valid_r;
  logic              valid_nxt;
  logic [DATA_W-1:0] data_r;

  assign up_ready   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_r <= res_data;
    end
  end

endmodule

// File: rtl/touch_tap_swipe_detector_core.sv
// ----------------------------------------------------------------------------
// Touch tap and swipe detector
// Turns one touch sample per tick into tap, release and swipe reports.
//
// Each input request is one time tick: the data-ready flag, the finger-down
// bit and the sample position. Exactly one result request comes out for each
// tick, in order. A tick passes an input register, the gesture logic and a
// result register, which holds the result and offers it to the receiver.
// One tick is accepted every cycle while out_tready stays high; the single pass
// through the gesture logic, with its two coordinate squares, sets that rate.
// When the receiver stalls, the result register holds its request and the
// input register takes one more tick before in_tready falls.
// Settings are written through the cfg channel, which is always ready; they
// should only change while no tick is in flight.
// Reset clears the touch state and counters, empties both registers and
// loads the default settings. There is no clearing pass.
// ----------------------------------------------------------------------------
module touch_tap_swipe_detector_core #(
  parameter int COORD_BITS = tts_pkg::COORD_BITS_DEFAULT,
  parameter int IN_W       = ((2 * COORD_BITS + 2 + 7) / 8) * 8,
  parameter int OUT_W      = ((2 * COORD_BITS + 6 + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // irq_pending, finger_down, touch_x, touch_y
  input  logic [IN_W-1:0]                   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tap_valid, tap_x, tap_y, swipe_kind, swipe_forward, released, touch_active
  output logic [OUT_W-1:0]                  out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tts_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [tts_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import tts_pkg::*;

  cfg_t             cfg;
  logic             advance;
  logic             up_ready;
  logic [IN_W-1:0]  item_data;
  logic [OUT_W-1:0] res_data;

  tts_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tts_in_stage #(.DATA_W(IN_W)) u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .down_ready (up_ready),
    .advance    (advance),
    .item_data  (item_data)
  );

  tts_gesture #(
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W),
    .OUT_W      (OUT_W)
  ) u_gesture (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .advance   (advance),
    .item_data (item_data),
    .res_data  (res_data)
  );

  tts_out_stage #(.DATA_W(OUT_W)) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .res_data   (res_data),
    .up_ready   (up_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
